FILE: src/rsaw_pkg.sv
// Package for the receive sequence acknowledge window.
// Holds the fixed field widths, the status and command codes and the shared types; no dependencies.
package rsaw_pkg;

    localparam int unsigned PKT_ID_W  = 16;
    localparam int unsigned STATUS_W  = 2;
    localparam int unsigned ACK_BITS_W = 32;
    localparam int unsigned SEQ_W     = 32;

    typedef logic [STATUS_W-1:0]   t_status;
    typedef logic [PKT_ID_W-1:0]   t_pkt_id;
    typedef logic [ACK_BITS_W-1:0] t_ack_bits;
    typedef logic [SEQ_W-1:0]      t_seq;

    localparam t_status ST_ACCEPTED  = 2'd0;
    localparam t_status ST_TOO_OLD   = 2'd1;
    localparam t_status ST_DUPLICATE = 2'd2;
    localparam t_status ST_REPORT    = 2'd3;

    localparam logic CMD_PACKET = 1'b0;
    localparam logic CMD_REPORT = 1'b1;

endpackage

FILE: src/receive_sequence_ack_window_core.sv
// Receive-side selective-acknowledge window: sequence extension, seen bitmap, reports.
// Depends on rsaw_pkg for field widths, status and command codes and types.
//
//  Channel | Direction | Handshake              | Payload
//  --------+-----------+------------------------+------------------------------------------
//  input   | in        | i_valid / o_stall      | i_command, i_packet_id
//  result  | out       | o_valid / i_stall      | o_status, o_ack_last_id, o_ack_bits
//
// Every transfer on the input produces exactly one result, via the input and then the
// result register. One item is taken per cycle unless the result side stalls: the input
// register feeds a single level of logic that updates the window state and loads the
// result register at the same edge. Reset (i_rst_n low at a rising edge) empties both
// registers and the window. A stall on the result side holds the result register, and
// the input side stalls only when the input register is full and cannot move on.
module receive_sequence_ack_window_core #(
    parameter int unsigned WINDOW  = 32,
    parameter int unsigned ID_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_command,
    input  rsaw_pkg::t_pkt_id   i_packet_id,
    output logic                o_valid,
    input  logic                i_stall,
    output rsaw_pkg::t_status   o_status,
    output rsaw_pkg::t_pkt_id   o_ack_last_id,
    output rsaw_pkg::t_ack_bits o_ack_bits
);
    import rsaw_pkg::*;

    // The seen bitmap covers the newest number and the WINDOW numbers before it.
    localparam int unsigned MAP_W = WINDOW + 1;
    localparam int unsigned IDX_W = $clog2(MAP_W);

    localparam t_seq ID_RANGE = t_seq'(64'd1 << ID_BITS);
    localparam t_seq ID_MASK  = t_seq'((64'd1 << ID_BITS) - 64'd1);
    localparam logic signed [SEQ_W-1:0] HALF_S = signed'(ID_RANGE >> 1);
    localparam logic signed [SEQ_W-1:0] WIN_S  = signed'(t_seq'(WINDOW));
    localparam t_seq WIN_U = t_seq'(WINDOW);

    // Input register.
    logic    r_in_valid;
    logic    r_in_cmd;
    t_pkt_id r_in_id;

    // Window state.
    t_seq             r_newest;
    t_seq             r_wrap;
    logic [MAP_W-1:0] r_seen;

    // Result register.
    logic      r_out_valid;
    t_status   r_out_status;
    t_pkt_id   r_out_last_id;
    t_ack_bits r_out_bits;

    logic out_adv;
    logic work;

    // Next values from the processing logic.
    t_seq             n_newest;
    t_seq             n_wrap;
    logic [MAP_W-1:0] n_seen;
    t_status          n_status;
    t_pkt_id          n_last_id;
    t_ack_bits        n_bits;
    t_ack_bits        report_bits;

    // Intermediate values of the packet path.
    t_seq             cur_raw;
    t_seq             cur;
    t_seq             newest_eff;
    logic [MAP_W-1:0] seen_eff;
    t_seq             dif;
    t_seq             back;
    t_seq             ahead;
    logic [MAP_W-1:0] bit_mask;

    // The result register can load when it is empty or its content leaves now.
    assign out_adv = !r_out_valid || !i_stall;
    assign work    = r_in_valid && out_adv;
    assign o_stall = r_in_valid && !out_adv;

    // Report bitmap: bit i holds whether newest minus (i+1) was seen.
    for (genvar gi = 0; gi < ACK_BITS_W; gi++) begin : g_report
        if (gi < WINDOW) begin : g_used
            assign report_bits[gi] = r_seen[gi+1];
        end else begin : g_unused
            assign report_bits[gi] = 1'b0;
        end
    end

    always_comb begin
        n_newest  = r_newest;
        n_wrap    = r_wrap;
        n_seen    = r_seen;
        n_status  = ST_ACCEPTED;
        n_last_id = '0;
        n_bits    = '0;

        // Extend the id against the wrap base. An empty window (newest at zero)
        // takes the extended number as its newest and starts with a clear bitmap.
        cur_raw    = r_wrap + (t_seq'(r_in_id) & ID_MASK);
        newest_eff = (r_newest == '0) ? cur_raw : r_newest;
        seen_eff   = (r_newest == '0) ? '0 : r_seen;

        // Move the number by one id range toward the newest. A forward wrap also
        // raises the wrap base. A distance of exactly half a range stays as is.
        dif = cur_raw - newest_eff;
        cur = cur_raw;
        if ($signed(dif) > HALF_S) begin
            cur = cur_raw - ID_RANGE;
        end else if ($signed(dif) < -HALF_S) begin
            cur    = cur_raw + ID_RANGE;
            n_wrap = r_wrap + ID_RANGE;
        end

        back     = newest_eff - cur;
        ahead    = t_seq'(0) - back;
        bit_mask = '0;

        if (r_in_cmd == CMD_REPORT) begin
            n_wrap    = r_wrap;
            n_status  = ST_REPORT;
            n_last_id = t_pkt_id'(r_newest & ID_MASK);
            n_bits    = report_bits;
        end else begin
            n_newest = newest_eff;
            n_seen   = seen_eff;
            if ($signed(back) > WIN_S) begin
                n_status = ST_TOO_OLD;
            end else begin
                if ($signed(back) < 0) begin
                    // Newer than the newest: slide the bitmap up, or clear it
                    // when the jump leaves the whole window behind.
                    if (ahead > WIN_U) begin
                        n_seen = '0;
                    end else begin
                        n_seen = seen_eff << ahead[IDX_W-1:0];
                    end
                    n_newest = cur;
                    bit_mask = MAP_W'(1);
                end else begin
                    bit_mask = MAP_W'(1) << back[IDX_W-1:0];
                end
                if ((n_seen & bit_mask) != '0) begin
                    n_status = ST_DUPLICATE;
                end else begin
                    n_seen   = n_seen | bit_mask;
                    n_status = ST_ACCEPTED;
                end
            end
        end
    end

    // Control and window state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_newest    <= '0;
            r_wrap      <= ID_RANGE;
            r_seen      <= '0;
        end else begin
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
            if (out_adv) begin
                r_out_valid <= r_in_valid;
            end
            if (work) begin
                r_newest <= n_newest;
                r_wrap   <= n_wrap;
                r_seen   <= n_seen;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_in_cmd <= i_command;
            r_in_id  <= i_packet_id;
        end
        if (work) begin
            r_out_status  <= n_status;
            r_out_last_id <= n_last_id;
            r_out_bits    <= n_bits;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_ack_last_id = r_out_last_id;
    assign o_ack_bits    = r_out_bits;

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for receive_sequence_ack_window_core.
// Uses rsaw_pkg for the field types and the status and command codes. Predicts every
// result with its own window model and compares each result transfer with the oldest one.
module testbench;

    import rsaw_pkg::*;

    // Window geometry as the core is built by default.
    localparam int    WIN         = 32;
    localparam t_seq  ID_SPAN     = 32'h0001_0000;
    localparam longint ID_HALF    = 32768;
    // A large forward step that still counts as "newer" after extension.
    localparam t_seq  WRAP_STEP   = 32'd32640;
    localparam int    HOLD_CYCLES = 60;
    localparam int    CYCLE_LIMIT = 50_000;
    localparam int    WALK_STEPS  = 12;

    // One expected or observed result transfer.
    typedef struct packed {
        t_status   status;
        t_pkt_id   last_id;
        t_ack_bits bits;
    } t_ack_result;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_valid     = 1'b0;
    logic      i_command   = CMD_PACKET;
    t_pkt_id   i_packet_id = '0;
    logic      i_stall     = 1'b0;
    logic      o_stall;
    logic      o_valid;
    t_status   o_status;
    t_pkt_id   o_ack_last_id;
    t_ack_bits o_ack_bits;

    receive_sequence_ack_window_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_command     (i_command),
        .i_packet_id   (i_packet_id),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_ack_last_id (o_ack_last_id),
        .o_ack_bits    (o_ack_bits)
    );

    // Free-running clock, period 10.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Window model. It is advanced once per accepted input transfer, in the same
    // order as the core sees them, so it always mirrors the core's state after
    // the last transfer it took.
    // ------------------------------------------------------------------------
    t_seq         win_newest;
    t_seq         win_base;
    logic [WIN:0] win_seen;

    t_ack_result ack_expect[$];

    int errors         = 0;
    int cycle_count    = 0;
    int inputs_taken   = 0;
    int results_seen   = 0;
    int stall_cycles   = 0;
    int base_moves     = 0;
    int status_hits[4] = '{0, 0, 0, 0};

    // Idling controls for the two sides, plus the long hold-off request.
    bit tx_idle_on    = 1'b0;
    bit rx_idle_on    = 1'b0;
    bit hold_request  = 1'b0;
    int hold_left     = 0;
    int rx_burst_left = 0;

    function automatic t_ack_result predict_ack(logic cmd, t_pkt_id id);
        t_ack_result  r;
        t_seq         cur;
        longint       lead;
        longint       lag;
        logic [WIN:0] mark;
        r = '0;
        if (cmd == CMD_REPORT) begin
            r.status  = ST_REPORT;
            r.last_id = win_newest[PKT_ID_W-1:0];
            r.bits    = win_seen[WIN:1];
            return r;
        end
        cur = win_base + t_seq'(id);
        // With nothing received (or the sequence space wrapped to zero), the
        // packet restarts the window on its own number.
        if (win_newest == '0) begin
            win_newest = cur;
            win_seen   = '0;
        end
        // Pull the candidate to within half an id range of the newest number.
        // Exactly half a range is left alone.
        lead = longint'(int'(cur - win_newest));
        if (lead > ID_HALF) begin
            cur = cur - ID_SPAN;
        end else if (lead < -ID_HALF) begin
            cur      = cur + ID_SPAN;
            win_base = win_base + ID_SPAN;
            base_moves++;
        end
        lag = longint'(int'(win_newest - cur));
        if (lag > WIN) begin
            r.status = ST_TOO_OLD;
            return r;
        end
        if (lag < 0) begin
            // Newer packet: slide the bitmap, or clear it on a jump past the window.
            if (-lag > WIN) begin
                win_seen = '0;
            end else begin
                win_seen = win_seen << (-lag);
            end
            win_newest = cur;
            lag        = 0;
        end
        mark      = '0;
        mark[lag] = 1'b1;
        if ((win_seen & mark) != '0) begin
            r.status = ST_DUPLICATE;
        end else begin
            win_seen = win_seen | mark;
            r.status = ST_ACCEPTED;
        end
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            errors++;
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
        end
    endtask

    // Input and result monitor. Both channels are sampled at the rising edge,
    // before any of this edge's updates land, so a transfer is seen exactly once.
    always @(posedge i_clk) begin : monitor
        t_ack_result want;
        if (!i_rst_n) begin
            win_newest = '0;
            win_base   = ID_SPAN;
            win_seen   = '0;
            ack_expect.delete();
        end else begin
            if (o_valid && !i_stall) begin
                results_seen++;
                if (ack_expect.size() == 0) begin
                    errors++;
                    $error("result transfer with no expected result: status %0d",
                           o_status);
                end else begin
                    want = ack_expect.pop_front();
                    check_field("status", 32'(want.status), 32'(o_status));
                    check_field("ack_last_id", 32'(want.last_id), 32'(o_ack_last_id));
                    check_field("ack_bits", want.bits, o_ack_bits);
                end
            end
            if (i_valid && !o_stall) begin
                inputs_taken++;
                want = predict_ack(i_command, i_packet_id);
                status_hits[want.status]++;
                ack_expect.insert(ack_expect.size(), want);
            end
        end
    end

    // Result side stall generator: random stall bursts while idling is enabled, and a long
    // counted hold-off when the pressure test asks for one.
    always @(posedge i_clk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
        end
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (rx_burst_left > 0) begin
            rx_burst_left--;
            i_stall <= 1'b1;
        end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
            rx_burst_left = $urandom_range(0, 6);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Watchdog, plus a count of cycles where the core held its input off.
    always @(posedge i_clk) begin
        cycle_count++;
        if (i_valid && o_stall) begin
            stall_cycles++;
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sender. Must be entered at a rising edge. Optionally idles for a burst,
    // then offers one item and returns at the edge where it transfers, leaving
    // valid high so back-to-back items follow one another directly.
    // ------------------------------------------------------------------------
    task automatic send_item(logic cmd, t_pkt_id id);
        int gap;
        gap = 0;
        if (tx_idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 7);
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_command   <= cmd;
        i_packet_id <= id;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // Stop offering and wait until every predicted result has come back.
    task automatic drain_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (ack_expect.size() != 0);
    endtask

    task automatic apply_reset();
        i_rst_n <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
    endtask

    // Hand-picked packets around the window edges, the exact half-range
    // distance, a forward wrap of the id and a stale id from before that wrap.
    task automatic test_directed_cases();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        send_item(CMD_REPORT, 16'hFFFF);   // report on an empty window
        send_item(CMD_PACKET, 16'h0000);   // first packet starts the window
        send_item(CMD_PACKET, 16'h0000);   // duplicate
        send_item(CMD_PACKET, 16'h0001);   // one newer
        send_item(CMD_PACKET, 16'hFFFF);   // id below zero, two back
        send_item(CMD_REPORT, 16'h0000);
        send_item(CMD_PACKET, 16'hFFE0);   // one past the window: too old
        send_item(CMD_PACKET, 16'hFFE1);   // exactly at the window's far edge
        send_item(CMD_REPORT, 16'h1234);
        send_item(CMD_PACKET, 16'h0021);   // slides by exactly the window size
        send_item(CMD_REPORT, 16'h0000);
        send_item(CMD_PACKET, 16'h0064);   // jumps past the window, map cleared
        send_item(CMD_PACKET, 16'h8064);   // exactly half a range ahead
        send_item(CMD_PACKET, 16'h0064);   // exactly half a range behind
        send_item(CMD_PACKET, 16'hF594);   // large step forward
        send_item(CMD_PACKET, 16'h6AC4);   // id wraps, base moves up
        send_item(CMD_PACKET, 16'h6AC4);   // duplicate after the wrap
        send_item(CMD_PACKET, 16'hF594);   // stale id from before the wrap
        send_item(CMD_PACKET, 16'h6AC3);   // just behind the newest
        send_item(CMD_PACKET, 16'h5555);
        send_item(CMD_PACKET, 16'hAAAA);
        send_item(CMD_REPORT, 16'hFFFF);
        drain_results();
    endtask

    // Mostly an in-order stream with light reordering and retransmits, mixed
    // with reports, jumps, half-range ids and plain noise. Idling on each side
    // is switched on and off per block so that quiet stretches occur too.
    task automatic test_random_stream();
        t_pkt_id head;
        int      pick;
        head = t_pkt_id'($urandom);
        for (int blk = 0; blk < 10; blk++) begin
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            for (int n = 0; n < 100; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 45) begin
                    head = head + t_pkt_id'($urandom_range(1, 3));
                    send_item(CMD_PACKET, head);
                end else if (pick < 60) begin
                    send_item(CMD_PACKET, head - t_pkt_id'($urandom_range(0, 40)));
                end else if (pick < 72) begin
                    send_item(CMD_REPORT, t_pkt_id'($urandom));
                end else if (pick < 80) begin
                    head = head + t_pkt_id'($urandom_range(4, 40));
                    send_item(CMD_PACKET, head);
                end else if (pick < 88) begin
                    send_item(CMD_PACKET, t_pkt_id'($urandom));
                end else if (pick < 93) begin
                    send_item(CMD_PACKET, head + t_pkt_id'($urandom_range(32767, 32769)));
                end else begin
                    head = head + t_pkt_id'($urandom_range(30000, 32767));
                    send_item(CMD_PACKET, head);
                end
            end
        end
        drain_results();
    endtask

    // The result side holds off for a long stretch while packets keep coming,
    // so the core's registers fill and it has to stall its input.
    task automatic test_backpressure();
        t_pkt_id head;
        tx_idle_on   = 1'b0;
        rx_idle_on   = 1'b0;
        head         = t_pkt_id'($urandom);
        hold_request = 1'b1;
        for (int n = 0; n < 24; n++) begin
            head = head + t_pkt_id'($urandom_range(0, 2));
            send_item((n % 6 == 5) ? CMD_REPORT : CMD_PACKET, head);
        end
        drain_results();
    endtask

    // Walk the newest number forward in large steps, back to back, so the id
    // wraps several times and the wrap base climbs, then probe inside and beyond the window.
    task automatic test_sequence_wrap();
        t_seq target;
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        target     = win_newest;
        for (int n = 0; n < WALK_STEPS; n++) begin
            target = target + WRAP_STEP;
            send_item(CMD_PACKET, target[PKT_ID_W-1:0]);
        end
        send_item(CMD_REPORT, 16'h0000);
        send_item(CMD_PACKET, target[PKT_ID_W-1:0] - 16'd3);    // inside the window
        send_item(CMD_PACKET, target[PKT_ID_W-1:0] - 16'd3);    // duplicate
        send_item(CMD_PACKET, target[PKT_ID_W-1:0] - 16'd40);   // too old
        send_item(CMD_REPORT, 16'h0000);
        drain_results();
    endtask

    initial begin
        apply_reset();
        test_directed_cases();
        test_random_stream();
        test_backpressure();
        test_sequence_wrap();
        repeat (8) @(posedge i_clk);
        if (ack_expect.size() != 0) begin
            errors++;
            $error("%0d expected results never arrived", ack_expect.size());
        end
        $display("Covered %0d input transfers and %0d result transfers: %0d accepted,",
                 inputs_taken, results_seen, status_hits[ST_ACCEPTED]);
        $display("%0d too old, %0d duplicate, %0d reports, %0d input stall cycles, %0d id wraps.",
                 status_hits[ST_TOO_OLD], status_hits[ST_DUPLICATE],
                 status_hits[ST_REPORT], stall_cycles, base_moves);
        if (errors == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
